@@ rtl/core/ktf_pkg.sv @@
package ktf_pkg;

    // Default state width, Q8.24 fraction bits, register and channel widths
    localparam int KTF_DATA_WIDTH = 32;
    localparam int KTF_FRAC       = 24;
    localparam int KTF_CFG_W      = 31;
    localparam int KTF_CFG_IDX_W  = 2;
    localparam int KTF_IO_W       = 32;

    // Register reset values (unsigned Q7.24)
    localparam logic [KTF_CFG_W-1:0] KTF_RST_ANGLE_NOISE = 31'd16777;
    localparam logic [KTF_CFG_W-1:0] KTF_RST_BIAS_NOISE  = 31'd50332;
    localparam logic [KTF_CFG_W-1:0] KTF_RST_MEAS_NOISE  = 31'd8388608;
    localparam logic [KTF_CFG_W-1:0] KTF_RST_PERIOD      = 31'd83886;

    typedef enum logic [KTF_CFG_IDX_W-1:0] {
        CFG_ANGLE_NOISE,
        CFG_BIAS_NOISE,
        CFG_MEAS_NOISE,
        CFG_SAMPLE_PERIOD
    } ktf_cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_P,
        ST_MUL,
        ST_UPD,
        ST_LOAD_D,
        ST_DIV,
        ST_LOAD_C,
        ST_EMIT
    } ktf_state_t;

    // Sequencer controls for the serial units
    typedef struct packed {
        logic load;
        logic step;
    } ktf_ctl_t;

endpackage

@@ rtl/core/ktf_in_if.sv @@
interface ktf_in_if
    import ktf_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [KTF_IO_W-1:0] accel_angle;
    logic signed [KTF_IO_W-1:0] gyro_rate;

    modport source (output valid, output accel_angle, output gyro_rate, input ready);
    modport sink   (input valid, input accel_angle, input gyro_rate, output ready);
endinterface

@@ rtl/core/ktf_out_if.sv @@
interface ktf_out_if
    import ktf_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [KTF_IO_W-1:0] filtered_angle;

    modport source (output valid, output filtered_angle, input ready);
    modport sink   (input valid, input filtered_angle, output ready);
endinterface

@@ rtl/core/ktf_mac_lane.sv @@
module ktf_mac_lane
    import ktf_pkg::*;
#(
    parameter int SW = KTF_DATA_WIDTH + 3,
    parameter int MB = KTF_DATA_WIDTH
)(
    input  logic                            clk,
    input  ktf_ctl_t                        ctl,
    input  logic signed [SW-1:0]            val,
    input  logic                            flip,
    input  logic                            mbit,
    output logic signed [SW+MB-KTF_FRAC:0]  prod
);

    localparam int AW = SW + MB;
    localparam int PW = AW - KTF_FRAC + 1;

    logic [SW-1:0] mag_reg, mag_next;
    logic          neg_reg, neg_next;
    logic [AW-1:0] acc_reg, acc_next;
    logic [PW-2:0] quot;

    // Load the multiplicand as sign and magnitude, then shift-add one
    // multiplier bit per cycle, most significant bit first
    always_comb
    begin
        mag_next = mag_reg;
        neg_next = neg_reg;
        acc_next = acc_reg;
        if (ctl.load)
        begin
            mag_next = val[SW-1] ? $unsigned(-val) : $unsigned(val);
            neg_next = val[SW-1] ^ flip;
            acc_next = '0;
        end
        else if (ctl.step)
        begin
            acc_next = {acc_reg[AW-2:0], 1'b0} + (mbit ? AW'(mag_reg) : '0);
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        neg_reg <= neg_next;
        acc_reg <= acc_next;
    end

    // Drop the fraction bits (truncate toward zero), then apply the sign
    assign quot = acc_reg[AW-1:KTF_FRAC];
    assign prod = neg_reg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

endmodule

@@ rtl/core/ktf_div_lane.sv @@
module ktf_div_lane
    import ktf_pkg::*;
#(
    parameter int W  = KTF_DATA_WIDTH,
    parameter int EW = KTF_DATA_WIDTH + 2
)(
    input  logic                clk,
    input  ktf_ctl_t            ctl,
    input  logic signed [W-1:0] num,
    input  logic                den_neg,
    input  logic [EW-2:0]       den_mag,
    output logic [W-1:0]        k_mag,
    output logic                k_neg
);

    logic [W-1:0]  nsh_reg, nsh_next;
    logic [EW-1:0] rem_reg, rem_next;
    logic [W:0]    quo_reg, quo_next;
    logic          ovf_reg, ovf_next;
    logic          neg_reg, neg_next;
    logic [EW-1:0] rem_sh;
    logic          ge;
    logic [W:0]    lim;

    // Restoring division, one quotient bit per cycle; the dividend is the
    // numerator magnitude followed by fraction zeros shifted in behind it
    always_comb
    begin
        nsh_next = nsh_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        ovf_next = ovf_reg;
        neg_next = neg_reg;
        rem_sh   = {rem_reg[EW-2:0], nsh_reg[W-1]};
        ge       = rem_sh >= {1'b0, den_mag};
        if (ctl.load)
        begin
            nsh_next = num[W-1] ? $unsigned(-num) : $unsigned(num);
            rem_next = '0;
            quo_next = '0;
            ovf_next = 1'b0;
            neg_next = num[W-1] ^ den_neg;
        end
        else if (ctl.step)
        begin
            nsh_next = {nsh_reg[W-2:0], 1'b0};
            rem_next = ge ? rem_sh - {1'b0, den_mag} : rem_sh;
            quo_next = {quo_reg[W-1:0], ge};
            ovf_next = ovf_reg | quo_reg[W];
        end
    end

    always_ff @(posedge clk)
    begin
        nsh_reg <= nsh_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        ovf_reg <= ovf_next;
        neg_reg <= neg_next;
    end

    // Clamp the magnitude to the signed range; a zero divisor gives zero gain
    assign lim = neg_reg ? ((W+1)'(1) << (W-1)) : (((W+1)'(1) << (W-1)) - 1'b1);

    always_comb
    begin
        if (den_mag == '0)
        begin
            k_mag = '0;
        end
        else if (ovf_reg || quo_reg > lim)
        begin
            k_mag = lim[W-1:0];
        end
        else
        begin
            k_mag = quo_reg[W-1:0];
        end
    end

    assign k_neg = neg_reg;

endmodule

@@ rtl/core/kalman_tilt_angle_filter_core.sv @@
// Two-state tilt Kalman filter (angle and gyro bias).
// Channels: sample carries accel_angle and gyro_rate (signed Q8.24), result
// carries filtered_angle (signed Q8.24, saturated). Both use valid/ready;
// a word moves on a clock edge with valid and ready high.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 angle process noise, 1 bias process noise, 2 measurement noise,
// 3 sample period, all unsigned Q7.24). Write only while the block is idle.
// Timing: one sample at a time. Six shift-add lanes run the prediction
// products against the sample period, one multiplier bit per cycle, then a
// restoring divider per gain forms the gains one quotient bit per cycle,
// then the lanes run the correction products against the gains. The next
// sample is accepted only once the result step has handed its result on
// and the block is back in idle.
// Stall: a finished result sits in the output register; the next sample is
// accepted and processed meanwhile, and its result waits in the last step
// until the register is free.
// Reset: registers return to their defaults, angle and bias clear and the
// covariance returns to identity; no result is pending.
module kalman_tilt_angle_filter_core
    import ktf_pkg::*;
#(
    parameter int DATA_WIDTH = KTF_DATA_WIDTH
)(
    input  logic                     clk,
    input  logic                     rst_n,
    ktf_in_if.sink                   sample,
    ktf_out_if.source                result,
    input  logic                     cfg_we,
    input  logic [KTF_CFG_IDX_W-1:0] cfg_index,
    input  logic [KTF_CFG_W-1:0]     cfg_data
);

    localparam int W     = DATA_WIDTH;
    localparam int MB    = (W > KTF_CFG_W) ? W : KTF_CFG_W;
    localparam int SW    = ((W > KTF_IO_W) ? W : KTF_IO_W) + 3;
    localparam int AW    = SW + MB;
    localparam int PW    = AW - KTF_FRAC + 1;
    localparam int UW    = PW + 1;
    localparam int EW    = MB + 2;
    localparam int NDIV  = W + KTF_FRAC;
    localparam int CW    = $clog2(NDIV + 1);
    localparam int OW    = ((W > KTF_IO_W) ? W : KTF_IO_W) + 1;
    localparam int LANES = 6;

    // Lane roles: each lane feeds one state value in both phases
    localparam int LN_ANGLE = 0;
    localparam int LN_P00   = 1;
    localparam int LN_P10   = 2;
    localparam int LN_P11   = 3;
    localparam int LN_P01   = 4;
    localparam int LN_BIAS  = 5;
    localparam logic [LANES-1:0] K1_LANES = 6'b101100;

    localparam logic signed [W-1:0] P_ONE = (W > KTF_FRAC + 1) ?
        (W'(1) <<< KTF_FRAC) : ((W'(1) <<< (W - 1)) - W'(1));

    ktf_state_t state_reg, state_next;
    logic       phase_reg, phase_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic [KTF_CFG_W-1:0] qa_reg, qa_next;
    logic [KTF_CFG_W-1:0] qg_reg, qg_next;
    logic [KTF_CFG_W-1:0] rn_reg, rn_next;
    logic [KTF_CFG_W-1:0] dt_reg, dt_next;

    logic signed [KTF_IO_W-1:0] accel_reg, accel_next;
    logic signed [KTF_IO_W-1:0] gyro_reg, gyro_next;

    logic signed [W-1:0] angle_reg, angle_next;
    logic signed [W-1:0] bias_reg, bias_next;
    logic signed [W-1:0] p00_reg, p00_next;
    logic signed [W-1:0] p01_reg, p01_next;
    logic signed [W-1:0] p10_reg, p10_next;
    logic signed [W-1:0] p11_reg, p11_next;

    logic [MB-1:0] mq0_reg, mq0_next;
    logic [MB-1:0] mq1_reg, mq1_next;
    logic [EW-2:0] den_mag_reg, den_mag_next;

    logic [KTF_IO_W-1:0] out_data_reg, out_data_next;
    logic                out_valid_reg, out_valid_next;

    ktf_ctl_t mac_ctl;
    ktf_ctl_t div_ctl;

    logic signed [SW-1:0] lane_val [LANES];
    logic [LANES-1:0]     lane_flip;
    logic [LANES-1:0]     lane_bit;
    logic signed [PW-1:0] lane_prod [LANES];

    logic signed [EW-1:0] den_val;
    logic signed [SW-1:0] err_val;
    logic [W-1:0]         k0_mag, k1_mag;
    logic                 k0_neg, k1_neg;

    function automatic logic signed [W-1:0] sat_w(input logic signed [UW-1:0] x);
        logic [UW-W:0] hi_bits;
        hi_bits = x[UW-1:W-1];
        if (hi_bits == '0 || hi_bits == '1)
            return x[W-1:0];
        else if (x[UW-1])
            return {1'b1, {(W-1){1'b0}}};
        else
            return {1'b0, {(W-1){1'b1}}};
    endfunction

    function automatic logic [KTF_IO_W-1:0] sat_out(input logic signed [W-1:0] x);
        logic signed [OW-1:0] ext;
        logic [OW-KTF_IO_W:0] hi_bits;
        ext     = OW'(x);
        hi_bits = ext[OW-1:KTF_IO_W-1];
        if (hi_bits == '0 || hi_bits == '1)
            return ext[KTF_IO_W-1:0];
        else if (ext[OW-1])
            return {1'b1, {(KTF_IO_W-1){1'b0}}};
        else
            return {1'b0, {(KTF_IO_W-1){1'b1}}};
    endfunction

    // Serial multiply lanes
    assign mac_ctl.load = (state_reg == ST_LOAD_P) || (state_reg == ST_LOAD_C);
    assign mac_ctl.step = (state_reg == ST_MUL);

    genvar gi;
    generate
        for (gi = 0; gi < LANES; gi++)
        begin : g_lane
            assign lane_bit[gi] = K1_LANES[gi] ? mq1_reg[MB-1] : mq0_reg[MB-1];

            ktf_mac_lane #(
                .SW (SW),
                .MB (MB)
            ) u_lane (
                .clk  (clk),
                .ctl  (mac_ctl),
                .val  (lane_val[gi]),
                .flip (lane_flip[gi]),
                .mbit (lane_bit[gi]),
                .prod (lane_prod[gi])
            );
        end
    endgenerate

    // Select lane operands: prediction rates against the sample period,
    // correction terms against the gains (covariance terms subtract)
    assign err_val = SW'(accel_reg) - SW'(angle_reg);

    always_comb
    begin
        if (state_reg == ST_LOAD_C)
        begin
            lane_val[LN_ANGLE]  = err_val;
            lane_flip[LN_ANGLE] = k0_neg;
            lane_val[LN_P00]    = SW'(p00_reg);
            lane_flip[LN_P00]   = ~k0_neg;
            lane_val[LN_P01]    = SW'(p01_reg);
            lane_flip[LN_P01]   = ~k0_neg;
            lane_val[LN_P10]    = SW'(p00_reg);
            lane_flip[LN_P10]   = ~k1_neg;
            lane_val[LN_P11]    = SW'(p01_reg);
            lane_flip[LN_P11]   = ~k1_neg;
            lane_val[LN_BIAS]   = err_val;
            lane_flip[LN_BIAS]  = k1_neg;
        end
        else
        begin
            lane_val[LN_ANGLE]  = SW'(gyro_reg) - SW'(bias_reg);
            lane_flip[LN_ANGLE] = 1'b0;
            lane_val[LN_P00]    = SW'($signed({1'b0, qa_reg})) - SW'(p01_reg) - SW'(p10_reg);
            lane_flip[LN_P00]   = 1'b0;
            lane_val[LN_P01]    = SW'(p11_reg);
            lane_flip[LN_P01]   = 1'b1;
            lane_val[LN_P10]    = SW'(p11_reg);
            lane_flip[LN_P10]   = 1'b1;
            lane_val[LN_P11]    = SW'($signed({1'b0, qg_reg}));
            lane_flip[LN_P11]   = 1'b0;
            lane_val[LN_BIAS]   = '0;
            lane_flip[LN_BIAS]  = 1'b0;
        end
    end

    // Gain dividers share the innovation variance
    assign div_ctl.load = (state_reg == ST_LOAD_D);
    assign div_ctl.step = (state_reg == ST_DIV);
    assign den_val      = EW'($signed({1'b0, rn_reg})) + EW'(p00_reg);

    ktf_div_lane #(
        .W  (W),
        .EW (EW)
    ) u_div_k0 (
        .clk     (clk),
        .ctl     (div_ctl),
        .num     (p00_reg),
        .den_neg (den_val[EW-1]),
        .den_mag (den_mag_reg),
        .k_mag   (k0_mag),
        .k_neg   (k0_neg)
    );

    ktf_div_lane #(
        .W  (W),
        .EW (EW)
    ) u_div_k1 (
        .clk     (clk),
        .ctl     (div_ctl),
        .num     (p10_reg),
        .den_neg (den_val[EW-1]),
        .den_mag (den_mag_reg),
        .k_mag   (k1_mag),
        .k_neg   (k1_neg)
    );

    // Sequencer: next state, counters, register writes, state update and result word
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        qa_next        = qa_reg;
        qg_next        = qg_reg;
        rn_next        = rn_reg;
        dt_next        = dt_reg;
        accel_next     = accel_reg;
        gyro_next      = gyro_reg;
        angle_next     = angle_reg;
        bias_next      = bias_reg;
        p00_next       = p00_reg;
        p01_next       = p01_reg;
        p10_next       = p10_reg;
        p11_next       = p11_reg;
        mq0_next       = mq0_reg;
        mq1_next       = mq1_reg;
        den_mag_next   = den_mag_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;

        // Drop the result word once taken
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        // Register writes
        if (cfg_we)
        begin
            case (ktf_cfg_idx_t'(cfg_index))
                CFG_ANGLE_NOISE:   qa_next = cfg_data;
                CFG_BIAS_NOISE:    qg_next = cfg_data;
                CFG_MEAS_NOISE:    rn_next = cfg_data;
                CFG_SAMPLE_PERIOD: dt_next = cfg_data;
                default:           qa_next = qa_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (sample.valid)
                begin
                    accel_next = sample.accel_angle;
                    gyro_next  = sample.gyro_rate;
                    state_next = ST_LOAD_P;
                end
            end
            ST_LOAD_P:
            begin
                mq0_next   = MB'(dt_reg);
                mq1_next   = MB'(dt_reg);
                cnt_next   = CW'(MB);
                phase_next = 1'b0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                mq0_next = {mq0_reg[MB-2:0], 1'b0};
                mq1_next = {mq1_reg[MB-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                angle_next = sat_w(UW'(angle_reg) + UW'(lane_prod[LN_ANGLE]));
                bias_next  = sat_w(UW'(bias_reg) + UW'(lane_prod[LN_BIAS]));
                p00_next   = sat_w(UW'(p00_reg) + UW'(lane_prod[LN_P00]));
                p01_next   = sat_w(UW'(p01_reg) + UW'(lane_prod[LN_P01]));
                p10_next   = sat_w(UW'(p10_reg) + UW'(lane_prod[LN_P10]));
                p11_next   = sat_w(UW'(p11_reg) + UW'(lane_prod[LN_P11]));
                state_next = phase_reg ? ST_EMIT : ST_LOAD_D;
            end
            ST_LOAD_D:
            begin
                den_mag_next = den_val[EW-1] ? (EW-1)'($unsigned(-den_val)) :
                                               (EW-1)'($unsigned(den_val));
                cnt_next     = CW'(NDIV);
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    state_next = ST_LOAD_C;
                end
            end
            ST_LOAD_C:
            begin
                mq0_next   = MB'(k0_mag);
                mq1_next   = MB'(k1_mag);
                cnt_next   = CW'(MB);
                phase_next = 1'b1;
                state_next = ST_MUL;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_data_next  = sat_out(angle_reg);
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= 1'b0;
            cnt_reg       <= '0;
            qa_reg        <= KTF_RST_ANGLE_NOISE;
            qg_reg        <= KTF_RST_BIAS_NOISE;
            rn_reg        <= KTF_RST_MEAS_NOISE;
            dt_reg        <= KTF_RST_PERIOD;
            angle_reg     <= '0;
            bias_reg      <= '0;
            p00_reg       <= P_ONE;
            p01_reg       <= '0;
            p10_reg       <= '0;
            p11_reg       <= P_ONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            qa_reg        <= qa_next;
            qg_reg        <= qg_next;
            rn_reg        <= rn_next;
            dt_reg        <= dt_next;
            angle_reg     <= angle_next;
            bias_reg      <= bias_next;
            p00_reg       <= p00_next;
            p01_reg       <= p01_next;
            p10_reg       <= p10_next;
            p11_reg       <= p11_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Sample, multiplier, divisor and result payload
    always_ff @(posedge clk)
    begin
        accel_reg    <= accel_next;
        gyro_reg     <= gyro_next;
        mq0_reg      <= mq0_next;
        mq1_reg      <= mq1_next;
        den_mag_reg  <= den_mag_next;
        out_data_reg <= out_data_next;
    end

    assign sample.ready          = (state_reg == ST_IDLE);
    assign result.valid          = out_valid_reg;
    assign result.filtered_angle = out_data_reg;

`ifndef SYNTHESIS
    a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL || state_reg == ST_DIV) |-> cnt_reg != '0)
        else $error("serial step counter ran out inside a multiply or divide pass");

    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        (sample.valid && sample.ready) |=> state_reg == ST_LOAD_P)
        else $error("accepted sample did not start the prediction pass");

    a_emit_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> phase_reg)
        else $error("result step reached before the correction pass");

    a_word_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(state_reg) == ST_EMIT)
        else $error("result word raised outside the result step");
`endif

endmodule
